>>> design/stereo_level_meter_unit_defines.svh
// Assertion macros for the stereo level meter RTL.
// Both macros assume a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef STEREO_LEVEL_METER_UNIT_DEFINES_SVH
`define STEREO_LEVEL_METER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SLM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLM_ASSERT_IMPL(label, ante, cons, msg)
`define SLM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/slm_pkg.sv
// Shared types and constants for the stereo level meter.
// No dependencies; used by slm_ctrl, slm_dp and stereo_level_meter_unit.
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

    localparam int BLOCK_DEFAULT = 64;

    localparam int SMP_W      = 24;
    localparam int LEVEL_W    = 16;
    localparam int HOLD_W     = 18;
    localparam int PROD_W     = 41;
    localparam int SQ_W       = 47;
    localparam int MS_W       = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd19661;
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 18'd12000;

    localparam int SCALE_SHIFT = 15;
    localparam int SCALE_ROUND = 16384;
    localparam int SAT_MAX     = 8388607;
    localparam int SAT_MIN     = -8388608;
    localparam logic [SMP_W-1:0] FULL_SCALE = 24'd1048576;

    localparam int PEAK_COEF  = 52;
    localparam int MS_COEF    = 131;
    localparam int COEF_ROUND = 32768;
    localparam int COEF_SHIFT = 16;

    localparam int SQRT_STEPS = 24;
    localparam int SQRT_CNT_W = 5;
    localparam int SQRT_TOP   = 46;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LEVEL = 2'd0;
    localparam t_cfg_idx CFG_RIGHT = 2'd1;
    localparam t_cfg_idx CFG_HOLD  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SAT,
        S_SQR,
        S_UPD,
        S_MS,
        S_RINIT,
        S_ROOT,
        S_RFIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic sat;
        logic sqr;
        logic upd;
        logic ms;
        logic root_init;
        logic root_step;
        logic root_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic block_end;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> design/slm_ctrl.sv
// Sequencer for the stereo level meter: steps one word through the datapath.
// Depends on slm_pkg and stereo_level_meter_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_level_meter_unit_defines.svh"

module slm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire slm_pkg::t_stat i_stat,
    output slm_pkg::t_cmd       o_cmd
);

    localparam logic [slm_pkg::SQRT_CNT_W-1:0] CNT_LAST =
        slm_pkg::SQRT_CNT_W'(slm_pkg::SQRT_STEPS - 1);

    slm_pkg::t_state r_state, n_state;
    logic [slm_pkg::SQRT_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slm_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            slm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = slm_pkg::S_MUL;
                end
            end
            slm_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = slm_pkg::S_SAT;
            end
            slm_pkg::S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = slm_pkg::S_SQR;
            end
            slm_pkg::S_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = slm_pkg::S_UPD;
            end
            slm_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = slm_pkg::S_MS;
            end
            slm_pkg::S_MS: begin
                o_cmd.ms = 1'b1;
                n_state  = i_stat.block_end ? slm_pkg::S_RINIT : slm_pkg::S_OUT;
            end
            slm_pkg::S_RINIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = slm_pkg::S_ROOT;
            end
            slm_pkg::S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = slm_pkg::S_RFIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            slm_pkg::S_RFIN: begin
                o_cmd.root_fin = 1'b1;
                n_state        = slm_pkg::S_OUT;
            end
            slm_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = slm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slm_pkg::S_IDLE;
            end
        endcase
    end

    `SLM_ASSERT_NEXT(a_accept_starts_mul, i_in_valid && !o_in_stall, r_state == slm_pkg::S_MUL, "accepted word did not start the multiply")
    `SLM_ASSERT_NEXT(a_root_exit, r_state == slm_pkg::S_ROOT && r_cnt == CNT_LAST, r_state == slm_pkg::S_RFIN, "square root did not finish after its last step")
    `SLM_ASSERT_NEXT(a_out_return, r_state == slm_pkg::S_OUT && i_stat.out_free, r_state == slm_pkg::S_IDLE, "sequencer did not return to idle after output load")

endmodule

`default_nettype wire

>>> design/slm_dp.sv
// Datapath for the stereo level meter: scaling, peak, mean square, square root,
// clip hold, configuration registers and output register. Depends on slm_pkg
// and stereo_level_meter_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_level_meter_unit_defines.svh"

module slm_dp #(
    parameter int BLOCK = slm_pkg::BLOCK_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire slm_pkg::t_cmd                         i_cmd,
    output slm_pkg::t_stat                             o_stat,
    input  wire logic                                  i_cfg_valid,
    input  wire logic [slm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [slm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [slm_pkg::SMP_W-1:0]      i_left_sample,
    input  wire logic signed [slm_pkg::SMP_W-1:0]      i_right_sample,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [slm_pkg::SMP_W-1:0]                  o_left_peak,
    output logic [slm_pkg::SMP_W-1:0]                  o_right_peak,
    output logic [slm_pkg::SMP_W-1:0]                  o_left_rms,
    output logic [slm_pkg::SMP_W-1:0]                  o_right_rms,
    output logic                                       o_clip_lit
);

    localparam int SMP_W  = slm_pkg::SMP_W;
    localparam int PROD_W = slm_pkg::PROD_W;
    localparam int SQ_W   = slm_pkg::SQ_W;
    localparam int MS_W   = slm_pkg::MS_W;
    localparam int HOLD_W = slm_pkg::HOLD_W;
    localparam int POS_W  = $clog2(BLOCK + 1);
    localparam int PP_W   = 31;
    localparam int MP_W   = 56;

    localparam logic [POS_W-1:0]  POS_END  = POS_W'(BLOCK);
    localparam logic [HOLD_W-1:0] HOLD_DEC = HOLD_W'(BLOCK);

    logic [slm_pkg::LEVEL_W-1:0] r_level;
    logic                        r_right_conn;
    logic [HOLD_W-1:0]           r_hold_samples;

    logic signed [SMP_W-1:0]  r_smp   [2];
    logic signed [PROD_W-1:0] r_prod  [2];
    logic [SMP_W-1:0]         r_mag   [2];
    logic [SQ_W-1:0]          r_x2    [2];
    logic                     r_pgt   [2];
    logic [SMP_W-1:0]         r_pdiff [2];
    logic                     r_msup  [2];
    logic [SQ_W-1:0]          r_msdiff[2];
    logic [SMP_W-1:0]         r_peak  [2];
    logic [MS_W-1:0]          r_ms    [2];
    logic [SMP_W-1:0]         r_rms   [2];
    logic [MS_W-1:0]          r_sx    [2];
    logic [MS_W-1:0]          r_res   [2];
    logic [MS_W-1:0]          r_bit;
    logic [HOLD_W-1:0]        r_hold;
    logic                     r_flag;
    logic [POS_W-1:0]         r_pos;
    logic                     r_out_valid;

    logic signed [PROD_W-1:0] n_sum   [2];
    logic signed [PROD_W-1:0] n_shr   [2];
    logic [SMP_W-1:0]         n_sat   [2];
    logic [SMP_W-1:0]         n_x     [2];
    logic [SMP_W-1:0]         n_mag   [2];
    logic                     n_clip;
    logic [PP_W-1:0]          n_pprod [2];
    logic [MP_W-1:0]          n_mprod [2];
    logic [MS_W-1:0]          n_mstep [2];
    logic [MS_W-1:0]          n_trial [2];
    logic [HOLD_W-1:0]        n_hold;
    logic [POS_W-1:0]         n_pos;

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            n_sum[ch] = r_prod[ch] + PROD_W'(slm_pkg::SCALE_ROUND);
            n_shr[ch] = n_sum[ch] >>> slm_pkg::SCALE_SHIFT;
            if (n_shr[ch] > PROD_W'(slm_pkg::SAT_MAX)) begin
                n_sat[ch] = SMP_W'(slm_pkg::SAT_MAX);
            end else if (n_shr[ch] < PROD_W'(slm_pkg::SAT_MIN)) begin
                n_sat[ch] = SMP_W'(slm_pkg::SAT_MIN);
            end else begin
                n_sat[ch] = n_shr[ch][SMP_W-1:0];
            end
        end
        n_x[0] = n_sat[0];
        n_x[1] = r_right_conn ? n_sat[1] : n_sat[0];
        for (int ch = 0; ch < 2; ch++) begin
            n_mag[ch]   = n_x[ch][SMP_W-1] ? (~n_x[ch] + 1'b1) : n_x[ch];
            n_pprod[ch] = PP_W'(r_pdiff[ch]) * PP_W'(slm_pkg::PEAK_COEF)
                        + PP_W'(slm_pkg::COEF_ROUND);
            n_mprod[ch] = MP_W'(r_msdiff[ch]) * MP_W'(slm_pkg::MS_COEF)
                        + MP_W'(slm_pkg::COEF_ROUND);
            n_mstep[ch] = MS_W'(n_mprod[ch][MP_W-1:slm_pkg::COEF_SHIFT]);
            n_trial[ch] = r_res[ch] + r_bit;
        end
        n_clip = (n_mag[0] > slm_pkg::FULL_SCALE) || (n_mag[1] > slm_pkg::FULL_SCALE);
        n_hold = (r_hold > HOLD_DEC) ? (r_hold - HOLD_DEC) : '0;
        n_pos  = r_pos + 1'b1;
    end

    assign o_stat.block_end = (n_pos == POS_END);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= slm_pkg::LEVEL_RESET;
            r_right_conn   <= 1'b0;
            r_hold_samples <= slm_pkg::HOLD_RESET;
            r_hold         <= '0;
            r_flag         <= 1'b0;
            r_pos          <= '0;
            r_out_valid    <= 1'b0;
            for (int ch = 0; ch < 2; ch++) begin
                r_peak[ch] <= '0;
                r_ms[ch]   <= '0;
                r_rms[ch]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    slm_pkg::CFG_LEVEL: r_level <= i_cfg_data[slm_pkg::LEVEL_W-1:0];
                    slm_pkg::CFG_RIGHT: r_right_conn <= i_cfg_data[0];
                    slm_pkg::CFG_HOLD:  r_hold_samples <= i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.sat && n_clip) begin
                r_hold <= r_hold_samples;
            end
            for (int ch = 0; ch < 2; ch++) begin
                if (i_cmd.upd) begin
                    r_peak[ch] <= r_pgt[ch] ? r_mag[ch]
                        : r_peak[ch] - SMP_W'(n_pprod[ch][PP_W-1:slm_pkg::COEF_SHIFT]);
                end
                if (i_cmd.ms) begin
                    r_ms[ch] <= r_msup[ch] ? (r_ms[ch] + n_mstep[ch])
                                           : (r_ms[ch] - n_mstep[ch]);
                end
                if (i_cmd.root_fin) begin
                    r_rms[ch] <= r_res[ch][SMP_W-1:0];
                end
            end
            if (i_cmd.ms) begin
                r_pos <= o_stat.block_end ? '0 : n_pos;
            end
            if (i_cmd.root_fin) begin
                r_hold <= n_hold;
                r_flag <= (n_hold != '0);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_smp[0] <= i_left_sample;
            r_smp[1] <= i_right_sample;
        end
        for (int ch = 0; ch < 2; ch++) begin
            if (i_cmd.mul) begin
                r_prod[ch] <= PROD_W'(r_smp[ch])
                            * PROD_W'($signed({1'b0, r_level}));
            end
            if (i_cmd.sat) begin
                r_mag[ch] <= n_mag[ch];
            end
            if (i_cmd.sqr) begin
                r_x2[ch]    <= SQ_W'(MS_W'(r_mag[ch]) * MS_W'(r_mag[ch]));
                r_pgt[ch]   <= r_mag[ch] > r_peak[ch];
                r_pdiff[ch] <= r_peak[ch] - r_mag[ch];
            end
            if (i_cmd.upd) begin
                r_msup[ch]   <= MS_W'(r_x2[ch]) >= r_ms[ch];
                r_msdiff[ch] <= (MS_W'(r_x2[ch]) >= r_ms[ch])
                              ? SQ_W'(MS_W'(r_x2[ch]) - r_ms[ch])
                              : SQ_W'(r_ms[ch] - MS_W'(r_x2[ch]));
            end
            if (i_cmd.root_init) begin
                r_sx[ch]  <= r_ms[ch];
                r_res[ch] <= '0;
            end else if (i_cmd.root_step) begin
                if (r_sx[ch] >= n_trial[ch]) begin
                    r_sx[ch]  <= r_sx[ch] - n_trial[ch];
                    r_res[ch] <= (r_res[ch] >> 1) + r_bit;
                end else begin
                    r_res[ch] <= r_res[ch] >> 1;
                end
            end
        end
        if (i_cmd.root_init) begin
            r_bit <= MS_W'(1) << slm_pkg::SQRT_TOP;
        end else if (i_cmd.root_step) begin
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.out_load) begin
            o_left_peak  <= r_peak[0];
            o_right_peak <= r_peak[1];
            o_left_rms   <= r_rms[0];
            o_right_rms  <= r_rms[1];
            o_clip_lit   <= r_flag;
        end
    end

    assign o_out_valid = r_out_valid;

    `SLM_ASSERT_IMPL(a_load_when_free, i_cmd.out_load, !r_out_valid || !i_out_stall, "output register overwritten while held")
    `SLM_ASSERT_IMPL(a_pos_range, 1'b1, r_pos < POS_END, "block position past block size")
    `SLM_ASSERT_NEXT(a_flag_follows_hold, i_cmd.root_fin, r_flag == (r_hold != '0), "clip flag disagrees with hold counter")

endmodule

`default_nettype wire

>>> design/stereo_level_meter_unit.sv
// Top level of the stereo level meter: sequencer plus datapath.
// Depends on slm_pkg, slm_ctrl and slm_dp.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one stereo word (left and
//   right sample). A word is taken at an edge with i_in_valid high and
//   o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one result word per input
//   word: both peaks, both RMS levels and the clip indicator.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   index 0 level, 1 right connected, 2 hold samples, others dropped. Write
//   only while no word is in flight.
// Sequence:
//   A word runs through six sequencer steps; the last one loads its result,
//   and the sequencer then returns to idle, so no new word is taken until the
//   result is loaded. The word that ends a block adds a setup step, 24 square
//   root steps of one result bit each in both channels, and a finish step.
//   A stalled result is held in the output register; the next word is then
//   accepted and processed but waits before the load until the result leaves.
//   Reset loads default settings, clears meters and counters, drops any word.
`timescale 1ns / 1ps
`default_nettype none

module stereo_level_meter_unit #(
    parameter int BLOCK = slm_pkg::BLOCK_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [slm_pkg::SMP_W-1:0]      i_left_sample,
    input  wire logic signed [slm_pkg::SMP_W-1:0]      i_right_sample,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [slm_pkg::SMP_W-1:0]                  o_left_peak,
    output logic [slm_pkg::SMP_W-1:0]                  o_right_peak,
    output logic [slm_pkg::SMP_W-1:0]                  o_left_rms,
    output logic [slm_pkg::SMP_W-1:0]                  o_right_rms,
    output logic                                       o_clip_lit,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [slm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [slm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    slm_pkg::t_cmd  w_cmd;
    slm_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    slm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    slm_dp #(
        .BLOCK (BLOCK)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_peak    (o_left_peak),
        .o_right_peak   (o_right_peak),
        .o_left_rms     (o_left_rms),
        .o_right_rms    (o_right_rms),
        .o_clip_lit     (o_clip_lit)
    );

endmodule

`default_nettype wire

>>> tb/sv/slm_meter_checker.sv
// Result checker for stereo_level_meter_unit: predicts peaks, RMS and clip state per word.
// Watches the input, output and register channels; depends on slm_pkg only.
`timescale 1ns / 1ps

module slm_meter_checker #(
    parameter int BLOCK = slm_pkg::BLOCK_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [slm_pkg::SMP_W-1:0]    i_left_sample,
    input  logic signed [slm_pkg::SMP_W-1:0]    i_right_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [slm_pkg::SMP_W-1:0]           i_left_peak,
    input  logic [slm_pkg::SMP_W-1:0]           i_right_peak,
    input  logic [slm_pkg::SMP_W-1:0]           i_left_rms,
    input  logic [slm_pkg::SMP_W-1:0]           i_right_rms,
    input  logic                                i_clip_lit,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [slm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_waiting
);

    import slm_pkg::*;

    typedef struct packed {
        logic [SMP_W-1:0] left_peak;
        logic [SMP_W-1:0] right_peak;
        logic [SMP_W-1:0] left_rms;
        logic [SMP_W-1:0] right_rms;
        logic             clip_lit;
    } t_reading;

    t_reading expected_readings[$];

    logic [LEVEL_W-1:0] gain;
    logic               right_used;
    logic [HOLD_W-1:0]  hold_len;
    logic [SMP_W-1:0]   peak[2];
    logic [MS_W-1:0]    msq[2];
    logic [SMP_W-1:0]   rms[2];
    logic [HOLD_W-1:0]  hold_left;
    logic               clip_on;
    int                 blk_pos;

    task automatic report_mismatch(input string what, input logic [SMP_W-1:0] got,
                                   input logic [SMP_W-1:0] want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        o_mismatches++;
    endtask

    function automatic logic signed [SMP_W-1:0] scale_sample(input logic signed [SMP_W-1:0] s,
                                                             input logic [LEVEL_W-1:0] g);
        longint prod;
        prod = longint'(s) * longint'(g);
        prod = (prod + SCALE_ROUND) >>> SCALE_SHIFT;
        if (prod > SAT_MAX) prod = SAT_MAX;
        if (prod < SAT_MIN) prod = SAT_MIN;
        return SMP_W'(prod);
    endfunction

    function automatic logic [SMP_W-1:0] magnitude(input logic signed [SMP_W-1:0] x);
        longint wide;
        wide = longint'(x);
        return SMP_W'(wide < 0 ? -wide : wide);
    endfunction

    function automatic logic [SMP_W-1:0] floor_root(input logic [MS_W-1:0] v);
        logic [SMP_W-1:0] r;
        logic [SMP_W-1:0] t;
        r = '0;
        for (int b = SMP_W - 1; b >= 0; b--) begin
            t = r | (SMP_W'(1) << b);
            if (64'(t) * 64'(t) <= 64'(v)) r = t;
        end
        return r;
    endfunction

    task automatic track_channel(input logic [SMP_W-1:0] mag, inout logic [SMP_W-1:0] pk,
                                 inout logic [MS_W-1:0] ms);
        logic [63:0] sq;
        logic [63:0] diff;
        logic [63:0] acc;
        if (mag > pk) begin
            pk = mag;
        end else begin
            diff = 64'(pk - mag);
            pk = pk - SMP_W'((diff * PEAK_COEF + COEF_ROUND) >> COEF_SHIFT);
        end
        sq = 64'(mag) * 64'(mag);
        acc = 64'(ms);
        if (sq >= acc) acc = acc + (((sq - acc) * MS_COEF + COEF_ROUND) >> COEF_SHIFT);
        else acc = acc - (((acc - sq) * MS_COEF + COEF_ROUND) >> COEF_SHIFT);
        ms = MS_W'(acc);
    endtask

    always @(posedge i_clk) begin : meter_track
        t_reading got;
        t_reading want;
        logic signed [SMP_W-1:0] lv;
        logic signed [SMP_W-1:0] rv;
        logic [SMP_W-1:0] lm;
        logic [SMP_W-1:0] rm;
        if (!i_rst_n) begin
            gain = LEVEL_RESET;
            right_used = 1'b0;
            hold_len = HOLD_RESET;
            for (int c = 0; c < 2; c++) begin
                peak[c] = '0;
                msq[c] = '0;
                rms[c] = '0;
            end
            hold_left = '0;
            clip_on = 1'b0;
            blk_pos = 0;
            o_mismatches = 0;
            expected_readings.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVEL: gain = i_cfg_data[LEVEL_W-1:0];
                    CFG_RIGHT: right_used = i_cfg_data[0];
                    CFG_HOLD:  hold_len = i_cfg_data[HOLD_W-1:0];
                    default:   ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.left_peak = i_left_peak;
                got.right_peak = i_right_peak;
                got.left_rms = i_left_rms;
                got.right_rms = i_right_rms;
                got.clip_lit = i_clip_lit;
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected result word, left peak", got.left_peak, '0);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.left_peak !== want.left_peak)
                        report_mismatch("left peak", got.left_peak, want.left_peak);
                    if (got.right_peak !== want.right_peak)
                        report_mismatch("right peak", got.right_peak, want.right_peak);
                    if (got.left_rms !== want.left_rms)
                        report_mismatch("left rms", got.left_rms, want.left_rms);
                    if (got.right_rms !== want.right_rms)
                        report_mismatch("right rms", got.right_rms, want.right_rms);
                    if (got.clip_lit !== want.clip_lit)
                        report_mismatch("clip lit", SMP_W'(got.clip_lit), SMP_W'(want.clip_lit));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                lv = scale_sample(i_left_sample, gain);
                rv = right_used ? scale_sample(i_right_sample, gain) : lv;
                lm = magnitude(lv);
                rm = magnitude(rv);
                if (lm > FULL_SCALE || rm > FULL_SCALE) hold_left = hold_len;
                track_channel(lm, peak[0], msq[0]);
                track_channel(rm, peak[1], msq[1]);
                blk_pos++;
                if (blk_pos >= BLOCK) begin
                    rms[0] = floor_root(msq[0]);
                    rms[1] = floor_root(msq[1]);
                    hold_left = (hold_left > BLOCK) ? hold_left - HOLD_W'(BLOCK) : '0;
                    clip_on = (hold_left != 0);
                    blk_pos = 0;
                end
                want.left_peak = peak[0];
                want.right_peak = peak[1];
                want.left_rms = rms[0];
                want.right_rms = rms[1];
                want.clip_lit = clip_on;
                expected_readings.push_back(want);
            end
        end
        o_waiting = expected_readings.size();
    end

endmodule

>>> tb/sv/tb_stereo_level_meter_unit.sv
// Testbench top for stereo_level_meter_unit: drives words and register writes, gives the verdict.
// Depends on slm_pkg, stereo_level_meter_unit and slm_meter_checker.
`timescale 1ns / 1ps

module tb_stereo_level_meter_unit;

    import slm_pkg::*;

    localparam t_cfg_idx CFG_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_OFF = 400;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [SMP_W-1:0] left_sample = '0;
    logic signed [SMP_W-1:0] right_sample = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [SMP_W-1:0]        left_peak;
    logic [SMP_W-1:0]        right_peak;
    logic [SMP_W-1:0]        left_rms;
    logic [SMP_W-1:0]        right_rms;
    logic                    clip_lit;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    t_cfg_idx                cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    int                      mismatches;
    int                      waiting;
    int                      idle_cycles = 0;
    bit                      tx_gaps = 1'b1;
    bit                      rx_gaps = 1'b1;
    bit                      flood_req = 1'b0;
    logic [LEVEL_W-1:0]      gain_now = LEVEL_RESET;

    stereo_level_meter_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_left_peak    (left_peak),
        .o_right_peak   (right_peak),
        .o_left_rms     (left_rms),
        .o_right_rms    (right_rms),
        .o_clip_lit     (clip_lit),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    slm_meter_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_left_peak    (left_peak),
        .i_right_peak   (right_peak),
        .i_left_rms     (left_rms),
        .i_right_rms    (right_rms),
        .i_clip_lit     (clip_lit),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_waiting      (waiting)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("stereo_level_meter_unit verification failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic signed [SMP_W-1:0] l, input logic signed [SMP_W-1:0] r);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        left_sample <= l;
        right_sample <= r;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_LEVEL) gain_now = data[LEVEL_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        if (in_valid) in_valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        logic [SMP_W-1:0] v;
        longint knee;
        case ($urandom_range(0, 5))
            0: v = SMP_W'($urandom);
            1: v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2: v = SMP_W'($urandom_range(0, 4095));
            3: begin
                knee = (gain_now == 0) ? SAT_MAX : (longint'(1) << 35) / gain_now;
                if (knee > SAT_MAX) knee = SAT_MAX;
                v = SMP_W'(knee + $urandom_range(0, 6) - 3);
            end
            4: v = SMP_W'($urandom) >> $urandom_range(1, 22);
            default: v = '0;
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = rx_gaps ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
            taken++;
            if (taken % 48 == 0) rx_gaps = ($urandom_range(0, 3) != 0);
            if (flood_req) begin
                flood_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF) @(negedge clk);
            end
        end
    end

    initial begin : word_source
        logic [LEVEL_W-1:0] g;
        logic [HOLD_W-1:0] h;
        logic signed [SMP_W-1:0] l;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unity gain, upper data bits must be masked off
        write_reg(CFG_LEVEL, 18'h28000);
        write_reg(CFG_RIGHT, 18'h3FFFF);
        write_reg(CFG_HOLD, 18'd100);
        write_reg(CFG_SPARE, 18'h155AA);
        cfg_valid <= 1'b0;
        send_word(24'sd0, 24'sd0);
        send_word(24'sd1, -24'sd1);
        send_word(-24'sd1, 24'sd1);
        send_word(24'sd1048576, -24'sd1048576);
        send_word(24'sd1048577, 24'sd0);
        send_word(24'sd0, -24'sd1048577);
        send_word(24'sh7FFFFF, 24'sh800000);
        send_word(24'sh800000, 24'sh7FFFFF);
        send_word(24'sd4096, 24'sd4096);
        send_word(24'sd0, 24'sd0);
        send_word(24'sd0, 24'sd0);
        wait_idle();
        write_reg(CFG_LEVEL, 18'h0FFFF);
        cfg_valid <= 1'b0;
        send_word(24'sh7FFFFF, 24'sh800000);
        send_word(24'sd4194400, -24'sd4194305);
        send_word(24'sd4194304, -24'sd4194304);
        wait_idle();
        write_reg(CFG_LEVEL, 18'd1);
        cfg_valid <= 1'b0;
        send_word(24'sd16384, -24'sd16384);
        send_word(-24'sd16385, 24'sd16383);
        send_word(24'sh7FFFFF, 24'sh800000);
        wait_idle();
        write_reg(CFG_LEVEL, 18'd0);
        write_reg(CFG_RIGHT, 18'd0);
        cfg_valid <= 1'b0;
        send_word(24'sh7FFFFF, 24'sh800000);
        wait_idle();
        write_reg(CFG_LEVEL, 18'd49152);
        cfg_valid <= 1'b0;
        send_word(24'sd5000, 24'sh7FFFFF);
        send_word(-24'sd2000000, 24'sd0);
        send_word(24'sh800000, 24'sd12);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0: g = 16'd0;
                1: g = 16'd1;
                2: g = 16'd32768;
                3: g = 16'd49152;
                4: g = 16'hFFFF;
                5: g = LEVEL_RESET;
                default: g = LEVEL_W'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0: h = '0;
                1: h = 18'd63;
                2: h = 18'd64;
                3: h = 18'd65;
                4: h = 18'd300;
                5: h = HOLD_RESET;
                6: h = 18'h3FFFF;
                default: h = HOLD_W'($urandom);
            endcase
            if (p == 0) h = 18'h3FFFF;
            if (p == 1) h = '0;
            write_reg(CFG_LEVEL, {2'($urandom), g});
            write_reg(CFG_RIGHT, {17'($urandom), 1'($urandom)});
            write_reg(CFG_HOLD, h);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            tx_gaps = ($urandom_range(0, 3) != 0);
            if (p == 2) begin
                tx_gaps = 1'b0;
                flood_req = 1'b1;
            end
            for (int n = 0; n < 55; n++) begin
                l = pick_sample();
                send_word(l, $urandom_range(0, 4) == 0 ? -l : pick_sample());
            end
        end

        wait_idle();
        repeat (40) @(negedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("stereo_level_meter_unit verification clean");
        else
            $display("stereo_level_meter_unit verification failed");
        $finish;
    end

endmodule
